// File: rtl/polygon_kernel_halfplane_clip_unit_assert.svh
// Assertion macros used by the controller of the polygon kernel clip unit.
`ifndef POLYGON_KERNEL_HALFPLANE_CLIP_UNIT_ASSERT_SVH
`define POLYGON_KERNEL_HALFPLANE_CLIP_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PHC_ASSERT(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);
`define PHC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define PHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PHC_ASSERT(label, cond, msg)
`define PHC_ASSERT_IMP(label, ante, cons, msg)
`define PHC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/phc_pkg.sv
// Types, constants and command structures of the polygon kernel clip unit.
package phc_pkg;

    localparam int COORD_W     = 20;
    localparam int BOX_W       = 19;
    localparam int REGION_CAP  = 20;
    localparam int MEM_DEPTH   = 2 * REGION_CAP;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int IDX_W       = 5;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int CROSS_W     = PROD_W + 1;
    localparam int HALF_W      = DIFF_W;
    localparam int DIV_NUM_W   = 3 * DIFF_W;
    localparam int DIV_DEN_W   = CROSS_W;
    localparam int QUOT_W      = DIFF_W;
    localparam int DIV_CNT_W   = $clog2(QUOT_W);
    localparam int MAX_STAR_DEF = 16;
    localparam logic [BOX_W-1:0] BOX_MIN_RST = BOX_W'(0);
    localparam logic [BOX_W-1:0] BOX_MAX_RST = BOX_W'(128000);
    localparam logic [2:0] ADDR_BOX_MIN = 3'd0;
    localparam logic [2:0] ADDR_BOX_MAX = 3'd4;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    typedef enum logic [1:0] {
        SRC_BOX,
        SRC_CROSS,
        SRC_P2
    } wr_src_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_BOX,
        ST_CLIP_START,
        ST_FETCH,
        ST_RDW,
        ST_MUL,
        ST_SUB,
        ST_FIRST,
        ST_DECIDE,
        ST_XLO,
        ST_XHI,
        ST_DSTART,
        ST_DWAIT,
        ST_PUSH_X,
        ST_PUSH_P2,
        ST_NEXT,
        ST_CLIP_END,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    typedef struct packed {
        logic              vin_load;
        logic              first_load;
        logic              prev_load;
        logic              edge_load;
        logic              edge_close;
        logic              mem_rd;
        logic [ADDR_W-1:0] rd_addr;
        logic              mem_wr;
        logic [ADDR_W-1:0] wr_addr;
        wr_src_t           wr_src;
        logic [1:0]        corner;
        logic              p2_from_mem;
        logic              p2_from_first;
        logic              cross_mul;
        logic              cross_sub;
        logic              first_save;
        logic              shift;
        logic              xmul_lo;
        logic              xmul_hi;
        logic              coord;
        logic              div_start;
        logic              div_store;
        logic              out_load;
        logic              out_empty;
    } phc_cmd_t;

    typedef struct packed {
        logic in1;
        logic in2;
        logic div_done;
    } phc_status_t;

endpackage

// File: rtl/phc_div.sv
// Restoring divider, one quotient bit per cycle, for the crossing point.
module phc_div
    import phc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [QUOT_W-1:0]    quot
);

    logic [DIV_NUM_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] dsh_reg;
    logic [QUOT_W-1:0]    q_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 fits;

    assign fits = rem_reg >= dsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == '0)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            dsh_reg <= {den, (QUOT_W-1)'(0)};
            q_reg   <= '0;
            cnt_reg <= DIV_CNT_W'(QUOT_W - 1);
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[QUOT_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// File: rtl/phc_datapath.sv
// Datapath: vertex and edge registers, region store, cross products and crossing points.
module phc_datapath
    import phc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  phc_cmd_t         cmd,
    input  point_t           vin,
    input  logic [BOX_W-1:0] box_min,
    input  logic [BOX_W-1:0] box_max,
    output phc_status_t      status,
    output point_t           out_point
);

    point_t mem [MEM_DEPTH];
    point_t v_reg, first_reg, prev_reg, a_reg, b_reg;
    point_t rdata_reg, p1_reg, p2_reg, pfirst_reg, cross_reg, out_reg;
    logic signed [PROD_W-1:0]  prod_a_reg, prod_b_reg;
    logic signed [CROSS_W-1:0] c1_reg, c2_reg, cfirst_reg;
    logic [HALF_W-1:0]         dp_mag_reg;
    logic [PROD_W-1:0]         prod_lo_reg, prod_hi_reg;
    logic [DIV_DEN_W-1:0]      den_mag_reg;
    logic                      qneg_reg;

    point_t                    wdata;
    point_t                    box_pt;
    logic signed [COORD_W-1:0] lo_c, hi_c;
    logic signed [DIFF_W-1:0]  dp;
    logic [HALF_W-1:0]         dp_mag;
    logic [CROSS_W-2:0]        c1_mag;
    logic signed [CROSS_W:0]   den;
    logic [DIV_NUM_W-1:0]      num;
    logic                      div_done;
    logic [QUOT_W-1:0]         quot;
    logic signed [QUOT_W:0]    qs;
    logic signed [COORD_W-1:0] p1c;
    logic signed [COORD_W+2:0] sum;
    logic signed [COORD_W-1:0] sat;

    assign lo_c = COORD_W'(box_min);
    assign hi_c = COORD_W'(box_max);

    always_comb begin
        case (cmd.corner)
            2'd0:    box_pt = '{y: lo_c, x: lo_c};
            2'd1:    box_pt = '{y: lo_c, x: hi_c};
            2'd2:    box_pt = '{y: hi_c, x: hi_c};
            default: box_pt = '{y: hi_c, x: lo_c};
        endcase
        case (cmd.wr_src)
            SRC_BOX:   wdata = box_pt;
            SRC_CROSS: wdata = cross_reg;
            default:   wdata = p2_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem[cmd.wr_addr] <= wdata;
        end
        if (cmd.mem_rd) begin
            rdata_reg <= mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.vin_load) v_reg <= vin;
        if (cmd.first_load) first_reg <= v_reg;
        if (cmd.first_load || cmd.prev_load) prev_reg <= v_reg;
        if (cmd.edge_load) begin
            a_reg <= prev_reg;
            b_reg <= cmd.edge_close ? first_reg : v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.p2_from_mem) begin
            p2_reg <= rdata_reg;
        end else if (cmd.p2_from_first) begin
            p2_reg <= pfirst_reg;
            c2_reg <= cfirst_reg;
        end
        if (cmd.cross_mul) begin
            prod_a_reg <= (DIFF_W'(b_reg.x) - DIFF_W'(a_reg.x))
                        * (DIFF_W'(p2_reg.y) - DIFF_W'(a_reg.y));
            prod_b_reg <= (DIFF_W'(b_reg.y) - DIFF_W'(a_reg.y))
                        * (DIFF_W'(p2_reg.x) - DIFF_W'(a_reg.x));
        end
        if (cmd.cross_sub) begin
            c2_reg <= CROSS_W'(prod_a_reg) - CROSS_W'(prod_b_reg);
        end
        if (cmd.first_save) begin
            pfirst_reg <= p2_reg;
            cfirst_reg <= c2_reg;
        end
        if (cmd.shift) begin
            p1_reg <= p2_reg;
            c1_reg <= c2_reg;
        end
    end

    // Crossing point p1 + dp * (-c1) / (c2 - c1), computed on magnitudes.
    assign dp = cmd.coord ? (DIFF_W'(p2_reg.y) - DIFF_W'(p1_reg.y))
                          : (DIFF_W'(p2_reg.x) - DIFF_W'(p1_reg.x));
    assign dp_mag = dp[DIFF_W-1] ? HALF_W'(-dp) : HALF_W'(dp);
    assign c1_mag = c1_reg[CROSS_W-1] ? (CROSS_W-1)'(-c1_reg) : (CROSS_W-1)'(c1_reg);
    assign den = (CROSS_W+1)'(c2_reg) - (CROSS_W+1)'(c1_reg);
    assign num = DIV_NUM_W'(prod_lo_reg) + {prod_hi_reg[PROD_W-1:0], HALF_W'(0)};

    always_ff @(posedge aclk) begin
        if (cmd.xmul_lo) begin
            dp_mag_reg  <= dp_mag;
            prod_lo_reg <= dp_mag * c1_mag[HALF_W-1:0];
            den_mag_reg <= den[CROSS_W] ? DIV_DEN_W'(-den) : DIV_DEN_W'(den);
            qneg_reg    <= dp[DIFF_W-1] ^ (!c1_reg[CROSS_W-1] && (c1_reg != '0))
                         ^ den[CROSS_W];
        end
        if (cmd.xmul_hi) begin
            prod_hi_reg <= dp_mag_reg * c1_mag[CROSS_W-2:HALF_W];
        end
    end

    phc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (num),
        .den     (den_mag_reg),
        .done    (div_done),
        .quot    (quot)
    );

    assign qs  = qneg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    assign p1c = cmd.coord ? p1_reg.y : p1_reg.x;
    assign sum = (COORD_W+3)'(p1c) + (COORD_W+3)'(qs);

    always_comb begin
        if (sum > (COORD_W+3)'(2**(COORD_W-1) - 1)) begin
            sat = {1'b0, {(COORD_W-1){1'b1}}};
        end else if (sum < -(COORD_W+3)'(2**(COORD_W-1))) begin
            sat = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            sat = sum[COORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_store) begin
            if (cmd.coord) cross_reg.y <= sat;
            else cross_reg.x <= sat;
        end
        if (cmd.out_load) begin
            out_reg <= cmd.out_empty ? '0 : rdata_reg;
        end
    end

    assign status.in1      = !c1_reg[CROSS_W-1];
    assign status.in2      = !c2_reg[CROSS_W-1];
    assign status.div_done = div_done;
    assign out_point       = out_reg;

endmodule

// File: rtl/phc_ctrl.sv
// Controller: sequences vertex intake, the clip passes over the region store and result output.
`include "polygon_kernel_halfplane_clip_unit_assert.svh"
module phc_ctrl
    import phc_pkg::*;
#(
    parameter int MAX_STAR = MAX_STAR_DEF
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tlast,
    output logic        s_tready,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic        m_tlast,
    output logic [1:0]  m_tuser,
    input  phc_status_t status,
    output phc_cmd_t    cmd
);

    localparam int VCW = $clog2(MAX_STAR + 1);

    state_t           state_reg, state_next;
    logic [VCW-1:0]   vcount_reg, vcount_next;
    logic [IDX_W-1:0] rcount_reg, rcount_next;
    logic [IDX_W-1:0] nout_reg, nout_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [1:0]       corner_reg, corner_next;
    logic             bank_reg, bank_next;
    logic             overflow_reg, overflow_next;
    logic             last_reg, last_next;
    logic             closing_reg, closing_next;
    logic             firstf_reg, firstf_next;
    logic             coord_reg, coord_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             m_tlast_reg, m_tlast_next;
    logic             empty_reg, empty_next;
    logic             too_many_reg, too_many_next;

    function automatic logic [ADDR_W-1:0] addr_of(input logic bank, input logic [IDX_W-1:0] idx);
        return bank ? (ADDR_W'(idx) + ADDR_W'(REGION_CAP)) : ADDR_W'(idx);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            vcount_reg   <= '0;
            rcount_reg   <= '0;
            nout_reg     <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            corner_reg   <= '0;
            bank_reg     <= 1'b0;
            overflow_reg <= 1'b0;
            last_reg     <= 1'b0;
            closing_reg  <= 1'b0;
            firstf_reg   <= 1'b0;
            coord_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
            empty_reg    <= 1'b0;
            too_many_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            vcount_reg   <= vcount_next;
            rcount_reg   <= rcount_next;
            nout_reg     <= nout_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            corner_reg   <= corner_next;
            bank_reg     <= bank_next;
            overflow_reg <= overflow_next;
            last_reg     <= last_next;
            closing_reg  <= closing_next;
            firstf_reg   <= firstf_next;
            coord_reg    <= coord_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tlast_reg  <= m_tlast_next;
            empty_reg    <= empty_next;
            too_many_reg <= too_many_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        vcount_next   = vcount_reg;
        rcount_next   = rcount_reg;
        nout_next     = nout_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        corner_next   = corner_reg;
        bank_next     = bank_reg;
        overflow_next = overflow_reg;
        last_next     = last_reg;
        closing_next  = closing_reg;
        firstf_next   = firstf_reg;
        coord_next    = coord_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tlast_next  = m_tlast_reg;
        empty_next    = empty_reg;
        too_many_next = too_many_reg;
        cmd           = '0;
        cmd.wr_src    = SRC_BOX;
        cmd.coord     = coord_reg;
        cmd.corner    = corner_reg;
        s_tready      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.vin_load = 1'b1;
                    last_next    = s_tlast;
                    closing_next = 1'b0;
                    if (vcount_reg == '0) begin
                        vcount_next = VCW'(1);
                        corner_next = '0;
                        state_next  = ST_BOX;
                    end else if (vcount_reg < VCW'(MAX_STAR)) begin
                        vcount_next = vcount_reg + VCW'(1);
                        state_next  = ST_CLIP_START;
                    end else begin
                        overflow_next = 1'b1;
                        if (s_tlast) begin
                            closing_next = 1'b1;
                            state_next   = ST_CLIP_START;
                        end
                    end
                end
            end
            ST_BOX: begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_addr = addr_of(1'b0, IDX_W'(corner_reg));
                cmd.wr_src  = SRC_BOX;
                cmd.first_load = (corner_reg == 2'd0);
                corner_next = corner_reg + 2'd1;
                if (corner_reg == 2'd3) begin
                    bank_next   = 1'b0;
                    rcount_next = IDX_W'(4);
                    if (last_reg) begin
                        closing_next = 1'b1;
                        state_next   = ST_CLIP_START;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CLIP_START: begin
                cmd.edge_load  = 1'b1;
                cmd.edge_close = closing_reg;
                cmd.prev_load  = !closing_reg;
                nout_next      = '0;
                j_next         = '0;
                firstf_next    = 1'b1;
                state_next     = (rcount_reg == '0) ? ST_CLIP_END : ST_FETCH;
            end
            ST_FETCH: begin
                if (firstf_reg) begin
                    cmd.mem_rd  = 1'b1;
                    cmd.rd_addr = addr_of(bank_reg, '0);
                    state_next  = ST_RDW;
                end else if ((j_reg + IDX_W'(1)) < rcount_reg) begin
                    cmd.mem_rd  = 1'b1;
                    cmd.rd_addr = addr_of(bank_reg, j_reg + IDX_W'(1));
                    state_next  = ST_RDW;
                end else begin
                    cmd.p2_from_first = 1'b1;
                    state_next        = ST_DECIDE;
                end
            end
            ST_RDW: begin
                cmd.p2_from_mem = 1'b1;
                state_next      = ST_MUL;
            end
            ST_MUL: begin
                cmd.cross_mul = 1'b1;
                state_next    = ST_SUB;
            end
            ST_SUB: begin
                cmd.cross_sub = 1'b1;
                state_next    = firstf_reg ? ST_FIRST : ST_DECIDE;
            end
            ST_FIRST: begin
                cmd.first_save = 1'b1;
                cmd.shift      = 1'b1;
                firstf_next    = 1'b0;
                state_next     = ST_FETCH;
            end
            ST_DECIDE: begin
                if (status.in1 && status.in2) begin
                    state_next = ST_PUSH_P2;
                end else if (status.in1 != status.in2) begin
                    coord_next = 1'b0;
                    state_next = ST_XLO;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_XLO: begin
                cmd.xmul_lo = 1'b1;
                state_next  = ST_XHI;
            end
            ST_XHI: begin
                cmd.xmul_hi = 1'b1;
                state_next  = ST_DSTART;
            end
            ST_DSTART: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (status.div_done) begin
                    cmd.div_store = 1'b1;
                    if (!coord_reg) begin
                        coord_next = 1'b1;
                        state_next = ST_XLO;
                    end else begin
                        state_next = ST_PUSH_X;
                    end
                end
            end
            ST_PUSH_X, ST_PUSH_P2: begin
                cmd.wr_src = (state_reg == ST_PUSH_X) ? SRC_CROSS : SRC_P2;
                if (nout_reg < IDX_W'(REGION_CAP)) begin
                    cmd.mem_wr  = 1'b1;
                    cmd.wr_addr = addr_of(!bank_reg, nout_reg);
                    nout_next   = nout_reg + IDX_W'(1);
                end else begin
                    overflow_next = 1'b1;
                end
                state_next = ((state_reg == ST_PUSH_X) && status.in2) ? ST_PUSH_P2 : ST_NEXT;
            end
            ST_NEXT: begin
                cmd.shift  = 1'b1;
                j_next     = j_reg + IDX_W'(1);
                state_next = ((j_reg + IDX_W'(1)) == rcount_reg) ? ST_CLIP_END : ST_FETCH;
            end
            ST_CLIP_END: begin
                bank_next   = !bank_reg;
                rcount_next = nout_reg;
                if (closing_reg) begin
                    k_next     = '0;
                    state_next = ST_EMIT_RD;
                end else if (last_reg) begin
                    closing_next = 1'b1;
                    state_next   = ST_CLIP_START;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                cmd.mem_rd  = (rcount_reg != '0);
                cmd.rd_addr = addr_of(bank_reg, k_reg);
                state_next  = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_empty = (rcount_reg == '0);
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = (rcount_reg == '0) || ((k_reg + IDX_W'(1)) == rcount_reg);
                    empty_next    = (rcount_reg == '0);
                    too_many_next = overflow_reg;
                    if (m_tlast_next) begin
                        vcount_next   = '0;
                        rcount_next   = '0;
                        overflow_next = 1'b0;
                        state_next    = ST_IDLE;
                    end else begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = {too_many_reg, empty_reg};

    `PHC_ASSERT(a_rcount_cap, rcount_reg <= IDX_W'(REGION_CAP), "region count over capacity")
    `PHC_ASSERT_IMP(a_wr_range, cmd.mem_wr, cmd.wr_addr < ADDR_W'(MEM_DEPTH), "store write out of range")
    `PHC_ASSERT_NEXT(a_run_clear, cmd.out_load && m_tlast_next, (vcount_reg == '0) && (rcount_reg == '0) && !overflow_reg, "run state not cleared after last item")

endmodule

// File: rtl/polygon_kernel_halfplane_clip_unit.sv
// Polygon kernel clip unit: top level with stream ports and configuration registers.
// Vertices arrive one item each; the first vertex of a polygon loads the clip square from
// box_min and box_max, and every further vertex, up to MAX_STAR in all, clips the stored
// region by one edge. Each edge crossing in a clip pass is found by the shared
// one-bit-per-cycle divider, which computes the crossing x and then y; the region store
// holds up to 20 points. The final vertex also clips by the closing edge and then sends
// the kernel points. New vertices are taken only between clip passes.
module polygon_kernel_halfplane_clip_unit
    import phc_pkg::*;
#(
    parameter int MAX_STAR = MAX_STAR_DEF
)(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // vx[19:0], vy[39:20]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // kx[19:0], ky[39:20]
    output logic        m_tlast,
    output logic [1:0]  m_tuser,   // kernel_empty[0], too_many[1]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [BOX_W-1:0] box_min_reg;
    logic [BOX_W-1:0] box_max_reg;
    phc_cmd_t         cmd;
    phc_status_t      status;
    point_t           out_point;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_min_reg <= BOX_MIN_RST;
            box_max_reg <= BOX_MAX_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == ADDR_BOX_MAX[2]) box_max_reg <= pwdata[BOX_W-1:0];
            else box_min_reg <= pwdata[BOX_W-1:0];
        end
    end

    assign prdata = (paddr[2] == ADDR_BOX_MAX[2]) ? 32'(box_max_reg) : 32'(box_min_reg);
    assign pready = 1'b1;

    phc_ctrl #(
        .MAX_STAR (MAX_STAR)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    phc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .vin       (point_t'(s_tdata)),
        .box_min   (box_min_reg),
        .box_max   (box_max_reg),
        .status    (status),
        .out_point (out_point)
    );

    assign m_tdata = out_point;

endmodule
